### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define HCB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// An implication checked at every clock edge outside reset.
`define HCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code builder package
// Sizes, payload types and the command and status groups shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_LEAVES     = 64;
    localparam int WEIGHT_BITS    = 12;
    localparam int SYMBOL_W       = 8;
    localparam int WEIGHT_FIELD_W = 12;
    localparam int CODE_W         = 63;
    localparam int LEN_W          = 6;

    localparam int LEAF_IDX_W = $clog2(MAX_LEAVES);
    localparam int COUNT_W    = $clog2(MAX_LEAVES + 1);
    localparam int NODE_SLOTS = 2 * MAX_LEAVES;
    localparam int NODE_W     = $clog2(NODE_SLOTS);
    // A node weight is at most MAX_LEAVES times the largest leaf weight.
    localparam int SUM_W      = WEIGHT_BITS + LEAF_IDX_W;

    // Strictly above every reachable node weight.
    localparam logic [SUM_W-1:0] WEIGHT_ABOVE_ALL = '1;

    typedef struct packed {
        logic [SYMBOL_W-1:0]       symbol;
        logic [WEIGHT_FIELD_W-1:0] weight;
        logic                      last_leaf;
    } hcb_leaf_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] out_symbol;
        logic [CODE_W-1:0]   code_bits;
        logic [LEN_W-1:0]    code_length;
        logic                overflowed;
        logic                last_code;
    } hcb_code_t;

    typedef struct packed {
        logic load;
        logic build_init;
        logic scan_init;
        logic scan_step;
        logic node_write;
        logic link_a;
        logic link_b;
        logic next_node;
        logic emit_init;
        logic walk_start;
        logic walk_read;
        logic walk_update;
        logic emit;
        logic next_leaf;
        logic batch_done;
    } hcb_cmd_t;

    typedef struct packed {
        logic multi_leaf;
        logic node_last;
        logic scan_at_end;
        logic walk_top;
        logic leaf_last;
        logic out_free;
    } hcb_status_t;

endpackage

### rtl/huffman_code_builder_core.sv
// ----------------------------------------------------------------------------
// Huffman code builder
// Loads weighted leaves, builds the code tree by repeated least-weight merges
// and returns one code per stored leaf in load order.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Beat
//  leaf      leaf_valid, leaf_ready, leaf_data    one symbol and weight
//  code      code_valid, code_ready, code_data    one symbol with its code
//
//  Leaves are taken one per cycle while the block is loading. The beat with
//  last_leaf set closes the batch; leaf_ready then stays low until the last
//  code beat has entered the result register.
//  For n stored leaves the build takes n-1 merges; each merge that creates node
//  k is dominated by the scan of nodes 1..k-1 through the single read port of
//  the node store. Each code is then built by a parent walk that climbs one
//  level per read and update step, and its emit waits while the code side
//  stalls.
//  Reset (rst_n, asynchronous, active low) empties the batch; the node and
//  symbol stores need no clearing because each entry is written before use.
//
// ----------------------------------------------------------------------------
module huffman_code_builder_core
    import hcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      leaf_valid,
    output logic      leaf_ready,
    input  hcb_leaf_t leaf_data,
    output logic      code_valid,
    input  logic      code_ready,
    output hcb_code_t code_data
);

    // Commands from the sequencer to the datapath and status coming back.
    hcb_cmd_t    cmd;
    hcb_status_t status;

    // The controller steps through load, merge and walk phases; it never
    // touches payload data, only the command and status groups.
    hcb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .leaf_valid (leaf_valid),
        .leaf_last  (leaf_data.last_leaf),
        .leaf_ready (leaf_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath owns the node store, the two-minimum search, the code walk
    // and the result register that decouples the code channel from the walk.
    hcb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .leaf_data  (leaf_data),
        .code_ready (code_ready),
        .code_valid (code_valid),
        .code_data  (code_data),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

### rtl/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// Huffman code builder controller
// Sequences leaf loading, the merge loop and the per-leaf code walk.
// ----------------------------------------------------------------------------
module hcb_ctrl
    import hcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        leaf_valid,
    input  logic        leaf_last,
    output logic        leaf_ready,
    input  hcb_status_t status,
    output hcb_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SCAN_START,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_MERGE_NODE,
        ST_MERGE_A,
        ST_MERGE_B,
        ST_EMIT_INIT,
        ST_WALK_START,
        ST_WALK_CHECK,
        ST_WALK_UPDATE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        leaf_ready = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                leaf_ready = 1'b1;
                cmd.load   = leaf_valid;
                if (leaf_valid && leaf_last)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (status.multi_leaf)
                begin
                    cmd.build_init = 1'b1;
                    state_next     = ST_SCAN_START;
                end
                else
                begin
                    state_next = ST_EMIT_INIT;
                end
            end
            ST_SCAN_START:
            begin
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_at_end)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:
            begin
                state_next = ST_MERGE_NODE;
            end
            ST_MERGE_NODE:
            begin
                cmd.node_write = 1'b1;
                state_next     = ST_MERGE_A;
            end
            ST_MERGE_A:
            begin
                cmd.link_a = 1'b1;
                state_next = ST_MERGE_B;
            end
            ST_MERGE_B:
            begin
                cmd.link_b = 1'b1;
                if (status.node_last)
                begin
                    state_next = ST_EMIT_INIT;
                end
                else
                begin
                    cmd.next_node = 1'b1;
                    state_next    = ST_SCAN_START;
                end
            end
            ST_EMIT_INIT:
            begin
                cmd.emit_init = 1'b1;
                state_next    = ST_WALK_START;
            end
            ST_WALK_START:
            begin
                cmd.walk_start = 1'b1;
                state_next     = ST_WALK_CHECK;
            end
            ST_WALK_CHECK:
            begin
                if (status.walk_top)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = ST_WALK_UPDATE;
                end
            end
            ST_WALK_UPDATE:
            begin
                cmd.walk_update = 1'b1;
                state_next      = ST_WALK_CHECK;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.leaf_last)
                    begin
                        cmd.batch_done = 1'b1;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        cmd.next_leaf = 1'b1;
                        state_next    = ST_WALK_START;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/hcb_datapath.sv
// ----------------------------------------------------------------------------
// Huffman code builder datapath
// Node store, leaf symbol store, the running two-minimum search, the code
// walk and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcb_datapath
    import hcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hcb_leaf_t   leaf_data,
    input  logic        code_ready,
    output logic        code_valid,
    output hcb_code_t   code_data,
    input  hcb_cmd_t    cmd,
    output hcb_status_t status
);

    // Node and leaf stores; node entry 0 stays unused so that 0 means none.
    logic [SUM_W-1:0]    node_weight [NODE_SLOTS];
    logic [NODE_W-1:0]   node_parent [NODE_SLOTS];
    logic [NODE_W-1:0]   node_left   [NODE_SLOTS];
    logic [SYMBOL_W-1:0] leaf_symbol [MAX_LEAVES];

    logic [SUM_W-1:0]    weight_q;
    logic [NODE_W-1:0]   parent_q;
    logic [NODE_W-1:0]   left_q;
    logic [SYMBOL_W-1:0] sym_q;

    // Control registers.
    logic [COUNT_W-1:0] leaf_count_reg, leaf_count_next;
    logic               ovf_reg, ovf_next;
    logic [NODE_W-1:0]  k_reg, k_next;
    logic [NODE_W-1:0]  scan_idx_reg, scan_idx_next;
    logic               scan_vld_reg;
    logic [COUNT_W-1:0] leaf_idx_reg, leaf_idx_next;
    logic               code_valid_reg, code_valid_next;

    // Payload registers.
    logic [NODE_W-1:0]  scan_pipe_idx_reg;
    logic [SUM_W-1:0]   best_w_reg, best_w_next;
    logic [NODE_W-1:0]  best_i_reg, best_i_next;
    logic [SUM_W-1:0]   second_w_reg, second_w_next;
    logic [NODE_W-1:0]  second_i_reg, second_i_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [NODE_W-1:0]  fnode_reg, fnode_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    hcb_code_t          out_reg, out_next;

    logic                  room;
    logic                  load_wr;
    logic [NODE_W-1:0]     load_node;
    logic [NODE_W-1:0]     total_nodes;
    logic [COUNT_W:0]      twice_count;
    logic [SUM_W-1:0]      merged_w;

    logic                  w_we, p_we, l_we;
    logic [NODE_W-1:0]     w_addr, p_addr, l_addr;
    logic [SUM_W-1:0]      w_data;
    logic [NODE_W-1:0]     p_data, l_data;
    logic                  rd_en;
    logic [NODE_W-1:0]     rd_addr;
    logic [LEAF_IDX_W-1:0] sym_rd_addr;

    assign room        = (leaf_count_reg < COUNT_W'(MAX_LEAVES));
    assign load_wr     = cmd.load && room;
    assign load_node   = NODE_W'(leaf_count_reg) + NODE_W'(1);
    assign twice_count = {leaf_count_reg, 1'b0};
    assign total_nodes = NODE_W'(twice_count - (COUNT_W + 1)'(1));
    assign merged_w    = best_w_reg + second_w_reg;

    // Write ports.
    always_comb
    begin
        w_we   = load_wr || cmd.node_write;
        w_addr = load_wr ? load_node : k_reg;
        w_data = load_wr ? SUM_W'(leaf_data.weight[WEIGHT_BITS-1:0]) : merged_w;

        l_we   = load_wr || cmd.node_write;
        l_addr = load_wr ? load_node : k_reg;
        l_data = load_wr ? '0 : best_i_reg;

        p_we   = load_wr || cmd.node_write || cmd.link_a || cmd.link_b;
        p_data = (cmd.link_a || cmd.link_b) ? k_reg : '0;
        priority if (load_wr)
        begin
            p_addr = load_node;
        end
        else if (cmd.node_write)
        begin
            p_addr = k_reg;
        end
        else if (cmd.link_a)
        begin
            p_addr = best_i_reg;
        end
        else
        begin
            p_addr = second_i_reg;
        end
    end

    // Read port shared by the search and the walk.
    always_comb
    begin
        rd_en = cmd.scan_step || cmd.walk_start || cmd.walk_read;
        priority if (cmd.scan_step)
        begin
            rd_addr = scan_idx_reg;
        end
        else if (cmd.walk_start)
        begin
            rd_addr = NODE_W'(leaf_idx_reg);
        end
        else
        begin
            rd_addr = parent_q;
        end
        sym_rd_addr = LEAF_IDX_W'(leaf_idx_reg - COUNT_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            node_weight[w_addr] <= w_data;
        end
        if (p_we)
        begin
            node_parent[p_addr] <= p_data;
        end
        if (l_we)
        begin
            node_left[l_addr] <= l_data;
        end
        if (load_wr)
        begin
            leaf_symbol[LEAF_IDX_W'(leaf_count_reg)] <= leaf_data.symbol;
        end
        if (rd_en)
        begin
            weight_q <= node_weight[rd_addr];
            parent_q <= node_parent[rd_addr];
            left_q   <= node_left[rd_addr];
        end
        if (cmd.walk_start)
        begin
            sym_q <= leaf_symbol[sym_rd_addr];
        end
    end

    // Next-state logic.
    always_comb
    begin
        leaf_count_next = leaf_count_reg;
        ovf_next        = ovf_reg;
        if (cmd.batch_done)
        begin
            leaf_count_next = '0;
            ovf_next        = 1'b0;
        end
        else if (cmd.load)
        begin
            if (room)
            begin
                leaf_count_next = leaf_count_reg + COUNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        k_next = k_reg;
        if (cmd.build_init)
        begin
            k_next = load_node;
        end
        else if (cmd.next_node)
        begin
            k_next = k_reg + NODE_W'(1);
        end

        scan_idx_next = scan_idx_reg;
        if (cmd.scan_init)
        begin
            scan_idx_next = NODE_W'(1);
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + NODE_W'(1);
        end

        // Running two smallest unparented nodes; ties keep the earlier index.
        best_w_next   = best_w_reg;
        best_i_next   = best_i_reg;
        second_w_next = second_w_reg;
        second_i_next = second_i_reg;
        if (cmd.scan_init)
        begin
            best_w_next   = WEIGHT_ABOVE_ALL;
            second_w_next = WEIGHT_ABOVE_ALL;
        end
        else if (scan_vld_reg && (parent_q == '0))
        begin
            if (weight_q < best_w_reg)
            begin
                second_w_next = best_w_reg;
                second_i_next = best_i_reg;
                best_w_next   = weight_q;
                best_i_next   = scan_pipe_idx_reg;
            end
            else if (weight_q < second_w_reg)
            begin
                second_w_next = weight_q;
                second_i_next = scan_pipe_idx_reg;
            end
        end

        leaf_idx_next = leaf_idx_reg;
        if (cmd.emit_init)
        begin
            leaf_idx_next = COUNT_W'(1);
        end
        else if (cmd.next_leaf)
        begin
            leaf_idx_next = leaf_idx_reg + COUNT_W'(1);
        end

        cur_next   = cur_reg;
        fnode_next = fnode_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        if (cmd.walk_start)
        begin
            cur_next  = NODE_W'(leaf_idx_reg);
            code_next = '0;
            len_next  = '0;
        end
        else if (cmd.walk_read)
        begin
            fnode_next = parent_q;
        end
        else if (cmd.walk_update)
        begin
            code_next[len_reg] = (cur_reg != left_q);
            len_next           = len_reg + LEN_W'(1);
            cur_next           = fnode_reg;
        end

        out_next = out_reg;
        if (cmd.emit)
        begin
            out_next.out_symbol  = sym_q;
            out_next.code_bits   = code_reg;
            out_next.code_length = len_reg;
            out_next.overflowed  = ovf_reg;
            out_next.last_code   = (leaf_idx_reg == leaf_count_reg);
        end

        code_valid_next = code_valid_reg;
        if (cmd.emit)
        begin
            code_valid_next = 1'b1;
        end
        else if (code_ready)
        begin
            code_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= '0;
            ovf_reg        <= 1'b0;
            k_reg          <= '0;
            scan_idx_reg   <= '0;
            scan_vld_reg   <= 1'b0;
            leaf_idx_reg   <= '0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            leaf_count_reg <= leaf_count_next;
            ovf_reg        <= ovf_next;
            k_reg          <= k_next;
            scan_idx_reg   <= scan_idx_next;
            scan_vld_reg   <= cmd.scan_step;
            leaf_idx_reg   <= leaf_idx_next;
            code_valid_reg <= code_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_pipe_idx_reg <= scan_idx_reg;
        best_w_reg        <= best_w_next;
        best_i_reg        <= best_i_next;
        second_w_reg      <= second_w_next;
        second_i_reg      <= second_i_next;
        cur_reg           <= cur_next;
        fnode_reg         <= fnode_next;
        code_reg          <= code_next;
        len_reg           <= len_next;
        out_reg           <= out_next;
    end

    assign status.multi_leaf  = (leaf_count_reg > COUNT_W'(1));
    assign status.node_last   = (k_reg == total_nodes);
    assign status.scan_at_end = (scan_idx_reg == (k_reg - NODE_W'(1)));
    assign status.walk_top    = (parent_q == '0) || (len_reg == '1);
    assign status.leaf_last   = (leaf_idx_reg == leaf_count_reg);
    assign status.out_free    = !code_valid_reg || code_ready;

    assign code_valid = code_valid_reg;
    assign code_data  = out_reg;

    `HCB_ASSERT(a_count_in_range, clk, rst_n, leaf_count_reg <= COUNT_W'(MAX_LEAVES), "leaf count above capacity")
    `HCB_ASSERT_IMP(a_children_differ, clk, rst_n, cmd.link_b, second_i_reg != best_i_reg, "merge children coincide")
    `HCB_ASSERT(a_min_order, clk, rst_n, scan_vld_reg |=> (best_w_reg <= second_w_reg), "two-minimum order broken")
    `HCB_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !code_valid_reg || code_ready, "result register overwritten")

endmodule

### verif/hcb_code_checker.sv
// ----------------------------------------------------------------------------
// Huffman code checker
// Watches the leaf and code channels and rebuilds each code tree from the
// accepted leaf beats. Every accepted code beat is compared field by field
// with the oldest code still due.
// ----------------------------------------------------------------------------
module hcb_code_checker
    import hcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        leaf_valid,
    input  logic        leaf_ready,
    input  hcb_leaf_t   leaf_data,
    input  logic        code_valid,
    input  logic        code_ready,
    input  hcb_code_t   code_data,
    output int unsigned fail_count,
    output int unsigned codes_pending
);

    logic [SUM_W-1:0]    node_wt     [NODE_SLOTS];
    logic [NODE_W-1:0]   node_up     [NODE_SLOTS];
    logic [NODE_W-1:0]   node_lchild [NODE_SLOTS];
    logic [SYMBOL_W-1:0] sym_store   [MAX_LEAVES];
    logic [COUNT_W-1:0]  stored_leaves;
    logic                dropped_any;
    hcb_code_t           codes_due[$];

    // Lowest-indexed unparented node of least weight among 1..top, not skip.
    function automatic int unsigned lightest_node(input int unsigned top,
                                                  input int unsigned skip);
        int unsigned      best;
        logic [SUM_W-1:0] best_wt;
        best    = 0;
        best_wt = WEIGHT_ABOVE_ALL;
        for (int unsigned k = 1; k <= top && k < NODE_SLOTS; k++)
        begin
            if (node_up[k] == '0 && k != skip && node_wt[k] < best_wt)
            begin
                best    = k;
                best_wt = node_wt[k];
            end
        end
        return best;
    endfunction

    // Stores one leaf; the closing beat builds the tree and queues its codes.
    task automatic predict_leaf(input hcb_leaf_t beat);
        int unsigned          n;
        int unsigned          a;
        int unsigned          b;
        int unsigned          c;
        int unsigned          f;
        int unsigned          len;
        logic [CODE_W-1:0]    code;
        hcb_code_t            due;
        if (stored_leaves < MAX_LEAVES)
        begin
            stored_leaves                = stored_leaves + 1'b1;
            sym_store[stored_leaves - 1] = beat.symbol;
            node_wt[stored_leaves]       = SUM_W'(beat.weight[WEIGHT_BITS-1:0]);
            node_up[stored_leaves]       = '0;
            node_lchild[stored_leaves]   = '0;
        end
        else
        begin
            dropped_any = 1'b1;
        end
        if (!beat.last_leaf)
            return;

        n = stored_leaves;
        if (n >= 2)
        begin
            for (int unsigned k = n + 1; k <= 2 * n - 1 && k < NODE_SLOTS; k++)
            begin
                a              = lightest_node(k - 1, 0);
                b              = lightest_node(k - 1, a);
                node_up[k]     = '0;
                node_lchild[k] = NODE_W'(a);
                node_wt[k]     = node_wt[a] + node_wt[b];
                if (a != 0)
                    node_up[a] = NODE_W'(k);
                if (b != 0)
                    node_up[b] = NODE_W'(k);
            end
        end

        // Walk from each leaf up to the root; the first edge lands in bit 0, the
        // least significant bit, and the root edge in the most significant used bit.
        for (int unsigned i = 1; i <= n; i++)
        begin
            code = '0;
            len  = 0;
            c    = i;
            f    = node_up[c];
            while (f != 0 && len < CODE_W)
            begin
                if (c != node_lchild[f])
                    code[len] = 1'b1;
                len++;
                c = f;
                f = node_up[c];
            end
            due.out_symbol  = sym_store[i - 1];
            due.code_bits   = code;
            due.code_length = LEN_W'(len);
            due.overflowed  = dropped_any;
            due.last_code   = (i == n);
            codes_due.push_back(due);
        end
        stored_leaves = '0;
        dropped_any   = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hcb_code_t want;
        if (!rst_n)
        begin
            stored_leaves = '0;
            dropped_any   = 1'b0;
            codes_due.delete();
        end
        else
        begin
            if (code_valid && code_ready)
            begin
                if (codes_due.size() == 0)
                begin
                    $error("code beat for symbol 0x%0h arrived with no code due",
                           code_data.out_symbol);
                    fail_count++;
                end
                else
                begin
                    want = codes_due.pop_front();
                    check_field("out_symbol", 64'(want.out_symbol),
                                64'(code_data.out_symbol));
                    check_field("code_bits", 64'(want.code_bits),
                                64'(code_data.code_bits));
                    check_field("code_length", 64'(want.code_length),
                                64'(code_data.code_length));
                    check_field("overflowed", 64'(want.overflowed),
                                64'(code_data.overflowed));
                    check_field("last_code", 64'(want.last_code),
                                64'(code_data.last_code));
                end
            end
            if (leaf_valid && leaf_ready)
                predict_leaf(leaf_data);
        end
        codes_pending = codes_due.size();
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Huffman code builder testbench
// Drives batches of leaf beats into the code builder, from hand-picked trees
// through random batches up to a batch past capacity, under several mixes of
// sender and receiver idling. A checker beside the block predicts the codes.
// ----------------------------------------------------------------------------
module testbench;

    import hcb_pkg::*;

    // No accepted beat on either channel for this many cycles ends the run.
    // The longest quiet stretch is the build of a full batch, and this limit
    // lies several times above it.
    localparam int STALL_LIMIT = 40000;
    // Cycles the receiver keeps code_ready low during the back-pressure test.
    localparam int LONG_HOLD   = 600;
    // Quiet cycles after the last code before the verdict.
    localparam int TAIL_CYCLES = 200;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        leaf_valid = 1'b0;
    logic        leaf_ready;
    hcb_leaf_t   leaf_data  = '0;
    logic        code_valid;
    logic        code_ready = 1'b0;
    hcb_code_t   code_data;
    int unsigned fail_count;
    int unsigned codes_pending;

    // Percent of cycles in which each side idles; changed per phase.
    int unsigned send_idle_pct = 33;
    int unsigned recv_idle_pct = 76;
    // Hold-off requests raised by the stimulus and served by the receiver.
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    // Leaf beats accepted so far, used to size the random phases.
    int unsigned leaves_sent   = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    huffman_code_builder_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .leaf_valid (leaf_valid),
        .leaf_ready (leaf_ready),
        .leaf_data  (leaf_data),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_data  (code_data)
    );

    hcb_code_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .leaf_valid    (leaf_valid),
        .leaf_ready    (leaf_ready),
        .leaf_data     (leaf_data),
        .code_valid    (code_valid),
        .code_ready    (code_ready),
        .code_data     (code_data),
        .fail_count    (fail_count),
        .codes_pending (codes_pending)
    );

    // Offers one leaf beat. Random idle cycles come first, then valid rises
    // with the payload and both stay put until the beat is taken at a rising
    // edge. The task returns on the following falling edge, so the next call
    // either lowers valid or moves straight on to the next payload.
    task automatic offer_leaf(input logic [SYMBOL_W-1:0] sym,
                              input logic [WEIGHT_FIELD_W-1:0] wt,
                              input logic last);
        hcb_leaf_t beat;
        beat.symbol    = sym;
        beat.weight    = wt;
        beat.last_leaf = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            leaf_valid <= 1'b0;
            @(negedge clk);
        end
        leaf_valid <= 1'b1;
        leaf_data  <= beat;
        do
            @(posedge clk);
        while (!leaf_ready);
        @(negedge clk);
        leaves_sent++;
    endtask

    // One batch of random leaves; the final beat closes it. Some batches use
    // tiny weights so that ties in the merge order are common.
    task automatic random_batch(input int unsigned size);
        bit light;
        light = ($urandom_range(3) == 0);
        for (int unsigned i = 0; i < size; i++)
        begin
            offer_leaf(SYMBOL_W'($urandom_range(255)),
                       light ? WEIGHT_FIELD_W'($urandom_range(3))
                             : WEIGHT_FIELD_W'($urandom_range(4095)),
                       i == size - 1);
        end
    endtask

    // Random batches until the phase has sent its share of leaves. Most
    // batches are small; about one in ten asks for up to full capacity, and
    // every batch is cut to what is left of the share.
    task automatic random_phase(input int unsigned budget);
        int unsigned stop_at;
        int unsigned batch_len;
        stop_at = leaves_sent + budget;
        while (leaves_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
                batch_len = $urandom_range(9, MAX_LEAVES);
            else
                batch_len = $urandom_range(1, 8);
            if (batch_len > stop_at - leaves_sent)
                batch_len = stop_at - leaves_sent;
            random_batch(batch_len);
        end
    endtask

    // The sender stops offering until every code due has come back.
    task automatic drain_codes();
        leaf_valid <= 1'b0;
        while (codes_pending != 0)
            @(negedge clk);
    endtask

    // Receiver. Outside a hold-off it raises code_ready at random according
    // to the current idle rate. A hold-off is counted here, in cycles, so the
    // sender keeps offering leaves while the block holds its result and stalls.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                code_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(negedge clk);
                hold_served++;
            end
            else
            begin
                code_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved a beat for too long.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((leaf_valid && leaf_ready) || (code_valid && code_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed trees. A lone leaf gets an empty code, at both ends of the
        // symbol and weight ranges.
        offer_leaf(8'h00, 12'h000, 1'b1);
        offer_leaf(8'hFF, 12'hFFF, 1'b1);
        // Two leaves, heavy one loaded first, so it becomes the right child.
        offer_leaf(8'hAA, 12'hFFF, 1'b0);
        offer_leaf(8'h55, 12'h000, 1'b1);
        // All weights equal: every pick is decided by the lowest index.
        for (int unsigned i = 0; i < 4; i++)
            offer_leaf(SYMBOL_W'(8'h10 + i), 12'd7, i == 3);
        // All weights zero.
        for (int unsigned i = 0; i < 5; i++)
            offer_leaf(SYMBOL_W'(8'h20 + i), 12'd0, i == 4);
        // Fibonacci weights give the deepest tree for the leaf count.
        offer_leaf(8'h30, 12'd1, 1'b0);
        offer_leaf(8'h31, 12'd1, 1'b0);
        offer_leaf(8'h32, 12'd2, 1'b0);
        offer_leaf(8'h33, 12'd3, 1'b0);
        offer_leaf(8'h34, 12'd5, 1'b0);
        offer_leaf(8'h35, 12'd8, 1'b0);
        offer_leaf(8'h36, 12'd13, 1'b1);
        // Largest weights: the merged sums reach well past the leaf width.
        for (int unsigned i = 0; i < 3; i++)
            offer_leaf(SYMBOL_W'(8'hF0 + i), 12'hFFF, i == 2);
        drain_codes();

        // Slow sender, mostly stalled receiver.
        send_idle_pct = 33;
        recv_idle_pct = 76;
        random_phase(8);
        drain_codes();

        // The other way round. It opens with a batch past capacity: the last
        // two beats are dropped, the closing one among them, so all 64 stored
        // leaves come back with the overflow flag set.
        send_idle_pct = 76;
        recv_idle_pct = 33;
        for (int unsigned i = 0; i < MAX_LEAVES + 2; i++)
            offer_leaf(SYMBOL_W'($urandom_range(255)),
                       WEIGHT_FIELD_W'($urandom_range(4095)),
                       i == MAX_LEAVES + 1);
        random_phase(8);
        drain_codes();

        // No idling. The receiver first holds off for a long stretch while
        // two batches are offered back to back, so the block stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        random_batch(5);
        random_batch(3);
        random_phase(8);
        drain_codes();

        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (fail_count == 0 && codes_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
